// File: rtl/core/vsft_pkg.sv
package vsft_pkg;

    localparam int TIME_W        = 63;
    localparam int ID_W          = 64;
    localparam int EVT_INTV_W    = 32;
    localparam int OUT_INTV_W    = 32;
    localparam int INTERVAL_BITS_DEF = 32;

    localparam int S_DATA_W      = 352;
    localparam int M_DATA_W      = 224;

    localparam logic [63:0]     FRAME_INTERVAL_NS = 64'd16000000;
    localparam logic [ID_W-1:0] ID_INVALID        = {ID_W{1'b1}};
    localparam logic [TIME_W-1:0] DEADLINE_RESET  = {TIME_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } rem_status_t;

endpackage

// File: rtl/core/vsft_rem.sv
module vsft_rem #(
    parameter int DIVIDEND_W = vsft_pkg::TIME_W,
    parameter int DIVISOR_W  = vsft_pkg::INTERVAL_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVISOR_W-1:0]  rem,
    output vsft_pkg::rem_status_t status
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W+1:0]  diff;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_LAST;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            if (!diff[DIVISOR_W+1])
                rem_next = diff[DIVISOR_W-1:0];
            else
                rem_next = trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign rem         = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: rtl/core/vsync_frame_time_tracker.sv
// channel     dir  tvalid/tready/tdata/tuser               contents
// s_axis      in   s_axis_tvalid s_axis_tready 352b 1b     vsync event or frame time query
// m_axis      out  m_axis_tvalid m_axis_tready 224b 1b     tracked values, one per input word
//
// a vsync event goes through EVT and OUT to the output register; a query goes from QRY
// to OUT if now precedes the frame time, else via JCMP, and via DIV and FIX when the frame
// time snaps: the remainder unit resolves one bit of the 63-bit jitter per cycle
// s_axis_tready is high only while the sequencer is idle
// a stalled output holds the sequencer before it loads the next result
// reset is asynchronous, active low, and restores the reset tracking values
module vsync_frame_time_tracker #(
    parameter int INTERVAL_BITS = vsft_pkg::INTERVAL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // vsync_time, intended_time, event_id, event_deadline, event_interval, now_time
    input  logic [vsft_pkg::S_DATA_W-1:0] s_axis_tdata,
    // kind
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // frame_time, current_id, current_deadline, current_interval
    output logic [vsft_pkg::M_DATA_W-1:0] m_axis_tdata,
    // accepted
    output logic                          m_axis_tuser
);

    localparam int TW = vsft_pkg::TIME_W;
    localparam int IW = vsft_pkg::ID_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVT  = 3'd1;
    localparam logic [2:0] ST_QRY  = 3'd2;
    localparam logic [2:0] ST_JCMP = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIX  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam logic [INTERVAL_BITS-1:0] INTV_RESET =
        vsft_pkg::FRAME_INTERVAL_NS[INTERVAL_BITS-1:0];

    logic [2:0] state_reg, state_next;

    logic [TW-1:0]             intended_reg, intended_next;
    logic [TW-1:0]             frame_time_reg, frame_time_next;
    logic signed [IW-1:0]      id_reg, id_next;
    logic [TW-1:0]             deadline_reg, deadline_next;
    logic [INTERVAL_BITS-1:0]  interval_reg, interval_next;
    logic                      accepted_reg, accepted_next;

    logic [TW-1:0]             in_vsync_reg;
    logic [TW-1:0]             in_intended_reg;
    logic signed [IW-1:0]      in_id_reg;
    logic [TW-1:0]             in_deadline_reg;
    logic [vsft_pkg::EVT_INTV_W-1:0] in_interval_reg;
    logic [TW-1:0]             in_now_reg;
    logic                      in_kind_reg;

    logic [TW-1:0]             jitter_reg, jitter_next;

    logic                      m_valid_reg, m_valid_next;
    logic [vsft_pkg::M_DATA_W-1:0] m_data_reg;
    logic                      m_user_reg;

    logic                      s_accept;
    logic                      out_load;
    logic [TW:0]               jitter_diff;
    logic [63:0]               intv64;
    logic [63:0]               evt_intv64;
    logic [INTERVAL_BITS-1:0]  evt_intv;
    logic [63:0]               rem64;
    logic                      rem_start;
    logic [INTERVAL_BITS-1:0]  rem_val;
    vsft_pkg::rem_status_t     rem_status;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    assign jitter_diff = {1'b0, in_now_reg} - {1'b0, frame_time_reg};
    assign intv64      = 64'(interval_reg);
    assign evt_intv64  = 64'(in_interval_reg);
    assign evt_intv    = evt_intv64[INTERVAL_BITS-1:0];
    assign rem64       = 64'(rem_val);
    assign rem_start   = (state_reg == ST_JCMP) && ({1'b0, jitter_reg} >= intv64);

    vsft_rem #(
        .DIVIDEND_W (TW),
        .DIVISOR_W  (INTERVAL_BITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (jitter_reg),
        .divisor  (interval_reg),
        .rem      (rem_val),
        .status   (rem_status)
    );

    always_comb
    begin
        state_next      = state_reg;
        intended_next   = intended_reg;
        frame_time_next = frame_time_reg;
        id_next         = id_reg;
        deadline_next   = deadline_reg;
        interval_next   = interval_reg;
        accepted_next   = accepted_reg;
        jitter_next     = jitter_reg;
        m_valid_next    = m_valid_reg;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                    state_next = s_axis_tuser ? ST_QRY : ST_EVT;
            end
            ST_EVT:
            begin
                if (in_intended_reg > intended_reg)
                begin
                    intended_next = in_intended_reg;
                    id_next       = (in_id_reg > id_reg) ? in_id_reg : vsft_pkg::ID_INVALID;
                    deadline_next = in_deadline_reg;
                    if (evt_intv != '0)
                        interval_next = evt_intv;
                end
                accepted_next = 1'b0;
                if (in_vsync_reg > frame_time_reg)
                begin
                    frame_time_next = in_vsync_reg;
                    accepted_next   = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_QRY:
            begin
                accepted_next = 1'b0;
                jitter_next   = jitter_diff[TW-1:0];
                // now before frame time: nothing to snap
                state_next    = jitter_diff[TW] ? ST_OUT : ST_JCMP;
            end
            ST_JCMP:
            begin
                state_next = rem_start ? ST_DIV : ST_OUT;
            end
            ST_DIV:
            begin
                if (rem_status.done)
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                frame_time_next = in_now_reg - rem64[TW-1:0];
                state_next      = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            intended_reg   <= '0;
            frame_time_reg <= '0;
            id_reg         <= vsft_pkg::ID_INVALID;
            deadline_reg   <= vsft_pkg::DEADLINE_RESET;
            interval_reg   <= INTV_RESET;
            accepted_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            intended_reg   <= intended_next;
            frame_time_reg <= frame_time_next;
            id_reg         <= id_next;
            deadline_reg   <= deadline_next;
            interval_reg   <= interval_next;
            accepted_reg   <= accepted_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jitter_reg <= jitter_next;
        if (s_accept)
        begin
            in_vsync_reg    <= s_axis_tdata[62:0];
            in_intended_reg <= s_axis_tdata[125:63];
            in_id_reg       <= s_axis_tdata[189:126];
            in_deadline_reg <= s_axis_tdata[252:190];
            in_interval_reg <= s_axis_tdata[284:253];
            in_now_reg      <= s_axis_tdata[347:285];
            in_kind_reg     <= s_axis_tuser;
        end
        if (out_load)
        begin
            m_data_reg <= {2'b00, intv64[vsft_pkg::OUT_INTV_W-1:0], deadline_reg,
                           id_reg, frame_time_reg};
            m_user_reg <= accepted_reg && !in_kind_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTH
    a_interval_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        interval_reg != '0)
        else $error("tracked interval is zero");

    a_frame_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> frame_time_reg >= $past(frame_time_reg))
        else $error("frame time moved backward");

    a_rem_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_status.busy |-> state_reg == ST_DIV)
        else $error("remainder unit running outside divide state");

    a_rem_below_interval: assert property (@(posedge clk) disable iff (!rst_n)
        rem_status.done |-> rem_val < interval_reg)
        else $error("remainder not below interval");

    a_load_needs_free_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && m_valid_reg && !m_axis_tready |=> state_reg == ST_OUT)
        else $error("result dropped while output stalled");
`endif

endmodule

// File: test/vsync_frame_time_tracker_tb.sv
module vsync_frame_time_tracker_tb;

    import vsft_pkg::*;

    localparam int WATCHDOG = 1000;
    localparam int RANDOM_WORDS = 400;
    localparam logic [OUT_INTV_W-1:0] RESET_INTERVAL = FRAME_INTERVAL_NS[OUT_INTV_W-1:0];
    localparam logic [ID_W-1:0] ID_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ID_W-1:0] ID_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic {
        KIND_EVENT = 1'b0,
        KIND_QUERY = 1'b1
    } word_kind_e;

    typedef struct packed {
        word_kind_e              kind;
        logic [TIME_W-1:0]       vsync_time;
        logic [TIME_W-1:0]       intended_time;
        logic [ID_W-1:0]         event_id;
        logic [TIME_W-1:0]       event_deadline;
        logic [EVT_INTV_W-1:0]   event_interval;
        logic [TIME_W-1:0]       now_time;
    } vsync_word_t;

    typedef struct packed {
        logic                    accepted;
        logic [TIME_W-1:0]       frame_time;
        logic [ID_W-1:0]         current_id;
        logic [TIME_W-1:0]       current_deadline;
        logic [OUT_INTV_W-1:0]   current_interval;
    } track_word_t;

    typedef struct packed {
        vsync_word_t stim;
        logic        typed;
        track_word_t goal;
    } sched_row_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;

    logic [TIME_W-1:0]     trk_intended;
    logic [TIME_W-1:0]     trk_frame;
    logic [ID_W-1:0]       trk_id;
    logic [TIME_W-1:0]     trk_deadline;
    logic [OUT_INTV_W-1:0] trk_interval;

    track_word_t track_q[$];
    sched_row_t  sched_rows[$];
    int          errors = 0;
    int          quiet_cycles = 0;
    bit          no_idle = 1'b0;

    vsync_frame_time_tracker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [TIME_W-1:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    function automatic vsync_word_t ev(logic [TIME_W-1:0] vt, logic [TIME_W-1:0] it,
                                       logic [ID_W-1:0] id, logic [TIME_W-1:0] dl,
                                       logic [EVT_INTV_W-1:0] iv);
        vsync_word_t w;
        w.kind = KIND_EVENT;
        w.vsync_time = vt;
        w.intended_time = it;
        w.event_id = id;
        w.event_deadline = dl;
        w.event_interval = iv;
        w.now_time = rand63();
        return w;
    endfunction

    function automatic vsync_word_t qy(logic [TIME_W-1:0] now);
        vsync_word_t w;
        w.kind = KIND_QUERY;
        w.vsync_time = rand63();
        w.intended_time = rand63();
        w.event_id = {$urandom, $urandom};
        w.event_deadline = rand63();
        w.event_interval = $urandom;
        w.now_time = now;
        return w;
    endfunction

    function automatic track_word_t want(logic acc, logic [TIME_W-1:0] ft,
                                         logic [ID_W-1:0] id, logic [TIME_W-1:0] dl,
                                         logic [OUT_INTV_W-1:0] iv);
        track_word_t t;
        t.accepted = acc;
        t.frame_time = ft;
        t.current_id = id;
        t.current_deadline = dl;
        t.current_interval = iv;
        return t;
    endfunction

    function automatic void add_row(vsync_word_t s, logic typed, track_word_t g);
        sched_row_t r;
        r.stim = s;
        r.typed = typed;
        r.goal = g;
        sched_rows.push_back(r);
    endfunction

    // tracker state update for one accepted word
    function automatic track_word_t track_step(vsync_word_t w);
        track_word_t r;
        logic [TIME_W-1:0] jitter;
        r.accepted = 1'b0;
        if (w.kind == KIND_EVENT)
        begin
            if (w.intended_time > trk_intended)
            begin
                trk_intended = w.intended_time;
                trk_id = ($signed(w.event_id) > $signed(trk_id)) ? w.event_id : ID_INVALID;
                trk_deadline = w.event_deadline;
                if (w.event_interval != '0)
                    trk_interval = w.event_interval;
            end
            if (w.vsync_time > trk_frame)
            begin
                trk_frame = w.vsync_time;
                r.accepted = 1'b1;
            end
        end
        else if (w.now_time >= trk_frame)
        begin
            jitter = w.now_time - trk_frame;
            if (jitter >= trk_interval)
                trk_frame = w.now_time - jitter % trk_interval;
        end
        r.frame_time = trk_frame;
        r.current_id = trk_id;
        r.current_deadline = trk_deadline;
        r.current_interval = trk_interval;
        return r;
    endfunction

    // random word, mostly well-formed against the tracked state
    function automatic vsync_word_t make_word(bit wide);
        vsync_word_t w;
        int unsigned pick;
        int unsigned idsel;
        w = qy(rand63());
        w.now_time = rand63();
        if (wide)
        begin
            w.kind = word_kind_e'($urandom_range(0, 1));
            return w;
        end
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            w.kind = KIND_EVENT;
            w.intended_time = trk_intended + TIME_W'($urandom_range(1, 20000000));
            idsel = $urandom_range(0, 9);
            if (idsel < 7)
                w.event_id = trk_id + 1;
            else if (idsel == 7)
                w.event_id = trk_id;
            else if (idsel == 8)
                w.event_id = {$urandom, $urandom};
            else
                w.event_id = ID_INVALID;
            w.event_deadline = w.intended_time + TIME_W'($urandom_range(0, 40000000));
            w.event_interval = ($urandom_range(0, 3) == 0) ? '0 : $urandom_range(1, 20000000);
            if ($urandom_range(0, 4) == 0 && trk_frame > 1000)
                w.vsync_time = trk_frame - TIME_W'($urandom_range(0, 1000));
            else
                w.vsync_time = trk_frame + TIME_W'($urandom_range(0, 20000000));
        end
        else if (pick < 90)
        begin
            w.kind = KIND_QUERY;
            if ($urandom_range(0, 7) == 0 && trk_frame > 1000)
                w.now_time = trk_frame - TIME_W'($urandom_range(1, 1000));
            else
                w.now_time = trk_frame + TIME_W'($urandom_range(0, 3)) * TIME_W'(trk_interval)
                             + TIME_W'($urandom_range(0, trk_interval));
        end
        else
        begin
            w.kind = word_kind_e'($urandom_range(0, 1));
            w.intended_time = rand63() >> $urandom_range(30, 62);
            w.vsync_time = rand63() >> $urandom_range(30, 62);
            w.now_time = rand63() >> $urandom_range(30, 62);
        end
        return w;
    endfunction

    task automatic send_word(vsync_word_t w, logic typed, track_word_t goal);
        int gap;
        track_word_t got;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, w.now_time, w.event_interval, w.event_deadline,
                         w.event_id, w.intended_time, w.vsync_time};
        s_axis_tuser <= w.kind;
        do @(posedge clk); while (!s_axis_tready);
        got = track_step(w);
        track_q.push_back(typed ? goal : got);
    endtask

    function automatic void flag(string what, logic [63:0] exp_v, logic [63:0] act_v);
        if (errors < 10)
            $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
        errors++;
    endfunction

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side
    initial
    begin
        track_word_t seen;
        track_word_t exp_w;
        int stall;
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            seen.accepted = m_axis_tuser;
            seen.frame_time = m_axis_tdata[62:0];
            seen.current_id = m_axis_tdata[126:63];
            seen.current_deadline = m_axis_tdata[189:127];
            seen.current_interval = m_axis_tdata[221:190];
            if (track_q.size() == 0)
                flag("unexpected word", '0, m_axis_tdata[63:0]);
            else
            begin
                exp_w = track_q.pop_front();
                if (seen.accepted !== exp_w.accepted)
                    flag("accepted", 64'(exp_w.accepted), 64'(seen.accepted));
                if (seen.frame_time !== exp_w.frame_time)
                    flag("frame_time", 64'(exp_w.frame_time), 64'(seen.frame_time));
                if (seen.current_id !== exp_w.current_id)
                    flag("current_id", exp_w.current_id, seen.current_id);
                if (seen.current_deadline !== exp_w.current_deadline)
                    flag("current_deadline", 64'(exp_w.current_deadline),
                         64'(seen.current_deadline));
                if (seen.current_interval !== exp_w.current_interval)
                    flag("current_interval", 64'(exp_w.current_interval),
                         64'(seen.current_interval));
            end
        end
    end

    // stimulus
    initial
    begin
        int head_rows;
        trk_intended = '0;
        trk_frame = '0;
        trk_id = ID_INVALID;
        trk_deadline = DEADLINE_RESET;
        trk_interval = RESET_INTERVAL;

        add_row(qy(63'd0), 1'b1, want(1'b0, 63'd0, ID_INVALID, DEADLINE_RESET, RESET_INTERVAL));
        add_row(qy(63'd15999999), 1'b1,
                want(1'b0, 63'd0, ID_INVALID, DEADLINE_RESET, RESET_INTERVAL));
        add_row(qy(63'd16000000), 1'b1,
                want(1'b0, 63'd16000000, ID_INVALID, DEADLINE_RESET, RESET_INTERVAL));
        // now before frame time
        add_row(qy(63'd5), 1'b1,
                want(1'b0, 63'd16000000, ID_INVALID, DEADLINE_RESET, RESET_INTERVAL));
        add_row(ev(63'd0, 63'd0, 64'd7, 63'd123, 32'd100), 1'b1,
                want(1'b0, 63'd16000000, ID_INVALID, DEADLINE_RESET, RESET_INTERVAL));
        add_row(ev(63'd16000001, 63'd1000, ID_INVALID, 63'd0, 32'd0), 1'b1,
                want(1'b1, 63'd16000001, ID_INVALID, 63'd0, RESET_INTERVAL));
        add_row(ev(63'd5, 63'd2000, 64'd0, DEADLINE_RESET, 32'd1), 1'b1,
                want(1'b0, 63'd16000001, 64'd0, DEADLINE_RESET, 32'd1));
        add_row(qy(63'd16000101), 1'b1,
                want(1'b0, 63'd16000101, 64'd0, DEADLINE_RESET, 32'd1));
        // id not increasing
        add_row(ev(63'd0, 63'd3000, 64'd0, 63'd42, 32'hFFFF_FFFF), 1'b1,
                want(1'b0, 63'd16000101, ID_INVALID, 63'd42, 32'hFFFF_FFFF));
        add_row(ev(63'd16000101, 63'd4000, ID_MAX, 63'd1, 32'h8000_0000), 1'b1,
                want(1'b0, 63'd16000101, ID_MAX, 63'd1, 32'h8000_0000));
        add_row(ev(63'd0, 63'd5000, ID_MIN, 63'd500, 32'd0), 1'b1,
                want(1'b0, 63'd16000101, ID_INVALID, 63'd500, 32'h8000_0000));
        add_row(ev(63'd0, 63'd6000, 64'd3, 63'd600, 32'd0), 1'b1,
                want(1'b0, 63'd16000101, 64'd3, 63'd600, 32'h8000_0000));
        add_row(qy(63'd6458451052), 1'b1,
                want(1'b0, 63'd6458451045, 64'd3, 63'd600, 32'h8000_0000));
        add_row(ev(63'd6458451046, 63'd7000, 64'd3, 63'd700, 32'd3), 1'b1,
                want(1'b1, 63'd6458451046, ID_INVALID, 63'd700, 32'd3));
        add_row(qy(63'd6458451056), 1'b1,
                want(1'b0, 63'd6458451055, ID_INVALID, 63'd700, 32'd3));
        add_row(qy(63'd6458451057), 1'b1,
                want(1'b0, 63'd6458451055, ID_INVALID, 63'd700, 32'd3));
        // stale intended and actual times
        add_row(ev(63'd6458451055, 63'd6999, 64'd100, 63'd1, 32'd9), 1'b1,
                want(1'b0, 63'd6458451055, ID_INVALID, 63'd700, 32'd3));
        add_row(ev(63'd6458451056, 63'd8000, 64'hFFFF_FFFF_FFFF_FFFE, 63'd800, 32'd0),
                1'b0, '0);
        head_rows = sched_rows.size();
        // saturating rows run last, nothing can advance past them
        add_row(ev(DEADLINE_RESET, DEADLINE_RESET, 64'd5, DEADLINE_RESET, 32'hFFFF_FFFF),
                1'b0, '0);
        add_row(qy(DEADLINE_RESET), 1'b0, '0);
        add_row(qy(63'd0), 1'b0, '0);
        add_row(ev(DEADLINE_RESET, DEADLINE_RESET, ID_MAX, 63'd0, 32'd1), 1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < head_rows; i++)
            send_word(sched_rows[i].stim, sched_rows[i].typed, sched_rows[i].goal);

        s_axis_tvalid <= 1'b0;
        while (track_q.size() != 0) @(posedge clk);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            no_idle = (n >= 150 && n < 200);
            send_word(make_word(n >= RANDOM_WORDS - 10), 1'b0, '0);
        end
        no_idle = 1'b0;

        for (int i = head_rows; i < sched_rows.size(); i++)
            send_word(sched_rows[i].stim, sched_rows[i].typed, sched_rows[i].goal);

        s_axis_tvalid <= 1'b0;
        while (track_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
